### design/cfs_pkg.sv
// ----------------------------------------------------------------------------
// cfs_pkg: shared types and constants
// Item formats, controller states, and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package cfs_pkg;

	localparam int MAX_N      = 8;
	localparam int MAX_NX     = 8;
	localparam int DEPTH      = 64;
	localparam int ADDR_W     = 6;
	localparam int DATA_W     = 32;
	localparam int DIM_W      = 4;
	localparam int CNT_W      = 7;
	localparam int ACC_W      = 52;
	localparam int CFG_IDX_W  = 1;

	localparam logic OP_LOAD_A = 1'b0;
	localparam logic OP_LOAD_B = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_N_SIZE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_RHS_COLS = 1'b1;

	typedef enum logic [1:0] {
		KIND_L   = 2'd0,
		KIND_X   = 2'd1,
		KIND_REJ = 2'd2
	} kind_t;

	typedef struct packed {
		logic               opcode;
		logic signed [31:0] value;
		logic               last;
	} in_item_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] result_value;
		logic               spd;
		logic               end_of_run;
	} out_item_t;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_CLR_OK,
		DP_CLR_D,
		DP_CLR_ACC,
		DP_LD_OPA_F,
		DP_LD_OPB_F,
		DP_LD_XF,
		DP_ACC,
		DP_LD_SYM,
		DP_DIV,
		DP_LD_QQ,
		DP_DACC,
		DP_SQRT,
		DP_SET_SPD
	} dp_op_t;

	typedef enum logic [1:0] {
		NUM_A,
		NUM_B,
		NUM_X
	} num_sel_t;

	typedef struct packed {
		dp_op_t              op;
		num_sel_t            num_sel;
		logic                a_we;
		logic                b_we;
		logic                f_we;
		logic                x_we;
		logic [ADDR_W-1:0]   a_addr;
		logic [ADDR_W-1:0]   b_addr;
		logic [ADDR_W-1:0]   f_addr;
		logic [ADDR_W-1:0]   x_addr;
		logic                out_ld;
		kind_t               out_kind;
		logic                out_zero;
		logic                out_end;
	} dp_cmd_t;

	typedef struct packed {
		logic ds_busy;
		logic out_full;
		logic spd;
	} dp_status_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_F_COL, ST_F_SUM, ST_F_RD1, ST_F_RD2, ST_F_LDB, ST_F_MUL, ST_F_ACC,
		ST_F_RDA, ST_F_RDA2, ST_F_DIV, ST_F_DIVW, ST_F_QMUL, ST_F_QACC,
		ST_F_PIV, ST_F_PIV2, ST_F_SQW, ST_F_SPD,
		ST_LO_RD, ST_LO_LD,
		ST_S_REJ,
		ST_FW_SUM, ST_FW_RD, ST_FW_LD, ST_FW_MUL, ST_FW_ACC,
		ST_FW_RDB, ST_FW_DIV, ST_FW_DW,
		ST_BW_SUM, ST_BW_RD, ST_BW_LD, ST_BW_MUL, ST_BW_ACC,
		ST_BW_RDS, ST_BW_DIV, ST_BW_DW,
		ST_XO_RD, ST_XO_LD
	} ctrl_state_t;

endpackage

### design/cholesky_factor_solve.sv
// ----------------------------------------------------------------------------
// cholesky_factor_solve: Q16.16 Cholesky factor and triangular solve
// Loads are accepted back to back while idle. A last item starts a run on one
// shared multiplier and one bit-serial divide/sqrt unit, then streams the results out.
// Reset clears control state, size registers (n_size 8, rhs_cols 1), load
// count and the SPD flag; the stores hold unknown data until written.
// ----------------------------------------------------------------------------
module cholesky_factor_solve import cfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// item input
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_item,
	// result output
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_item,
	// register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Controller: sequences loads, factor, forward/back substitution and
	// result streaming; owns the loop indices and the size registers.
	cfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_opcode (in_item.opcode),
		.in_last   (in_item.last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.status    (status),
		.cmd       (cmd)
	);

	// Datapath: A, B, L and X stores, the MAC, the divide/sqrt unit and
	// the output register that holds a result until it is taken.
	cfs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_value  (in_item.value),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

### design/cfs_ram.sv
// ----------------------------------------------------------------------------
// cfs_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module cfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### design/cfs_divsqrt.sv
// ----------------------------------------------------------------------------
// cfs_divsqrt: shared iterative divide / square root unit
// Q16.16 divide, one quotient bit per cycle, or integer square root of
// rad*65536, one root bit per cycle. Saturating.
// ----------------------------------------------------------------------------
module cfs_divsqrt import cfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start_div,
	input  logic               start_sqrt,
	input  logic signed [31:0] num,
	input  logic signed [31:0] den,
	input  logic [31:0]        rad,
	output logic               busy,
	output logic signed [31:0] result
);

	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	logic        busy_q;
	logic        sqrt_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic [47:0] dvd_q;
	logic [47:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [31:0] res_q;

	logic [31:0] num_mag, den_mag;
	logic [32:0] rem_dn, rem_sn, trial;
	logic        ge_d, ge_s;

	assign num_mag = num[31] ? 32'(-num) : 32'(num);
	assign den_mag = den[31] ? 32'(-den) : 32'(den);

	// one restoring step of each kind
	assign rem_dn = {rem_q[31:0], dvd_q[47]};
	assign ge_d   = rem_dn >= {1'b0, dvs_q};
	assign rem_sn = {rem_q[30:0], dvd_q[47:46]};
	assign trial  = {7'd0, quo_q[23:0], 2'b01};
	assign ge_s   = rem_sn >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start_div) begin
			if (den == '0) begin
				busy_q <= 1'b0;
			end else begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd48;
			end
		end else if (start_sqrt) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'd24;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_div) begin
			sqrt_q <= 1'b0;
			neg_q  <= num[31] ^ den[31];
			dvd_q  <= {num_mag, 16'd0};
			dvs_q  <= den_mag;
			quo_q  <= '0;
			rem_q  <= '0;
			if (den == '0) begin
				if (num == '0) begin
					res_q <= '0;
				end else begin
					res_q <= num[31] ? Q_MIN : Q_MAX;
				end
			end
		end else if (start_sqrt) begin
			sqrt_q <= 1'b1;
			dvd_q  <= {rad, 16'd0};
			quo_q  <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (sqrt_q) begin
					rem_q <= ge_s ? rem_sn - trial : rem_sn;
					quo_q <= {quo_q[46:0], ge_s};
					dvd_q <= {dvd_q[45:0], 2'b00};
				end else begin
					rem_q <= ge_d ? rem_dn - {1'b0, dvs_q} : rem_dn;
					quo_q <= {quo_q[46:0], ge_d};
					dvd_q <= {dvd_q[46:0], 1'b0};
				end
			end else if (sqrt_q) begin
				res_q <= {8'd0, quo_q[23:0]};
			end else if (neg_q) begin
				res_q <= (quo_q > 48'h0000_8000_0000) ? Q_MIN : 32'(-quo_q[31:0]);
			end else begin
				res_q <= (quo_q[47:31] != '0) ? Q_MAX : quo_q[31:0];
			end
		end
	end

	assign busy   = busy_q;
	assign result = res_q;

endmodule

### design/cfs_datapath.sv
// ----------------------------------------------------------------------------
// cfs_datapath: stores, multiply-accumulate, divide/sqrt and output register
// Executes one command per cycle from the controller.
// ----------------------------------------------------------------------------
module cfs_datapath import cfs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	input  logic signed [31:0] in_value,
	output dp_status_t         status,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_item
);

	logic signed [31:0] a_rd, b_rd, f_rd, x_rd;
	logic signed [31:0] ds_res;
	logic               ds_busy;

	logic signed [31:0]      opa_q, opb_q, sym_q;
	logic signed [63:0]      prod_s1;
	logic signed [ACC_W-1:0] acc_q, d_q;
	logic                    ok_q, spd_q;
	logic                    out_valid_q;
	out_item_t               out_q;

	logic signed [63:0]      rnd_full;
	logic signed [ACC_W-1:0] prod_rnd;
	logic signed [31:0]      num_src, num_sat, piv_sat, out_val;
	logic                    out_spd;

	cfs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
		.clk(clk), .wr_en(cmd.a_we), .wr_addr(cmd.a_addr), .wr_data(in_value),
		.rd_addr(cmd.a_addr), .rd_data(a_rd)
	);
	cfs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_b_ram (
		.clk(clk), .wr_en(cmd.b_we), .wr_addr(cmd.b_addr), .wr_data(in_value),
		.rd_addr(cmd.b_addr), .rd_data(b_rd)
	);
	cfs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_f_ram (
		.clk(clk), .wr_en(cmd.f_we), .wr_addr(cmd.f_addr), .wr_data(ds_res),
		.rd_addr(cmd.f_addr), .rd_data(f_rd)
	);
	cfs_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_x_ram (
		.clk(clk), .wr_en(cmd.x_we), .wr_addr(cmd.x_addr), .wr_data(ds_res),
		.rd_addr(cmd.x_addr), .rd_data(x_rd)
	);

	// v - s, saturated to 32 bits
	function automatic logic signed [31:0] sub_sat(logic signed [31:0] v,
		logic signed [ACC_W-1:0] s);
		logic signed [ACC_W:0] diff;
		diff = (ACC_W+1)'(v) - (ACC_W+1)'(s);
		if (diff[ACC_W:31] == '0 || diff[ACC_W:31] == '1) begin
			return diff[31:0];
		end
		return diff[ACC_W] ? 32'sh8000_0000 : 32'sh7fff_ffff;
	endfunction

	// product rounded half up to Q16.16
	assign rnd_full = (prod_s1 + 64'sd32768) >>> 16;
	assign prod_rnd = ACC_W'(rnd_full);

	always_comb begin
		case (cmd.num_sel)
			NUM_A:   num_src = sym_q;
			NUM_B:   num_src = b_rd;
			default: num_src = x_rd;
		endcase
	end

	assign num_sat = sub_sat(num_src, acc_q);
	assign piv_sat = sub_sat(a_rd, d_q);

	cfs_divsqrt u_divsqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_div (cmd.op == DP_DIV),
		.start_sqrt(cmd.op == DP_SQRT),
		.num       (num_sat),
		.den       (f_rd),
		.rad       (piv_sat[31] ? 32'd0 : 32'(piv_sat)),
		.busy      (ds_busy),
		.result    (ds_res)
	);

	always_ff @(posedge clk) begin
		prod_s1 <= opa_q * opb_q;
		case (cmd.op)
			DP_CLR_D:    d_q   <= '0;
			DP_CLR_ACC:  acc_q <= '0;
			DP_LD_OPA_F: opa_q <= f_rd;
			DP_LD_OPB_F: opb_q <= f_rd;
			DP_LD_XF: begin
				opa_q <= x_rd;
				opb_q <= f_rd;
			end
			DP_ACC:      acc_q <= acc_q + prod_rnd;
			DP_LD_SYM:   sym_q <= a_rd;
			DP_LD_QQ: begin
				opa_q <= ds_res;
				opb_q <= ds_res;
			end
			DP_DACC:     d_q <= d_q + prod_rnd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q  <= 1'b0;
			spd_q <= 1'b0;
		end else begin
			case (cmd.op)
				DP_CLR_OK:  ok_q <= 1'b1;
				DP_DIV: begin
					// mirrored entries must match exactly
					if (cmd.num_sel == NUM_A && a_rd != sym_q) begin
						ok_q <= 1'b0;
					end
				end
				DP_SQRT: begin
					if (piv_sat[31] || piv_sat == '0) begin
						ok_q <= 1'b0;
					end
				end
				DP_SET_SPD: spd_q <= ok_q;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cmd.out_kind)
			KIND_L: begin
				out_val = cmd.out_zero ? 32'sd0 : f_rd;
				out_spd = spd_q;
			end
			KIND_X: begin
				out_val = x_rd;
				out_spd = 1'b1;
			end
			default: begin
				out_val = '0;
				out_spd = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_q.kind         <= cmd.out_kind;
			out_q.result_value <= out_val;
			out_q.spd          <= out_spd;
			out_q.end_of_run   <= cmd.out_end;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_item        = out_q;
	assign status.ds_busy  = ds_busy;
	assign status.out_full = out_valid_q;
	assign status.spd      = spd_q;

endmodule

### design/cfs_ctrl.sv
// ----------------------------------------------------------------------------
// cfs_ctrl: sequencer for load, factor, solve and result streaming
// Holds the size registers, load counter and loop indices.
// ----------------------------------------------------------------------------
module cfs_ctrl import cfs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_opcode,
	input  logic                 in_last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  dp_status_t           status,
	output dp_cmd_t              cmd
);

	ctrl_state_t      state_q, state_d;
	logic [DIM_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
	logic [CNT_W-1:0] ld_cnt_q, ld_cnt_d;
	logic [DIM_W-1:0] n_cfg_q, nx_cfg_q;

	logic [DIM_W-1:0] n_eff, nx_eff, i_inc, j_inc, k_inc, n_m1, nx_m1;
	logic [7:0]       cap;

	// row * stride + col
	function automatic logic [ADDR_W-1:0] idx(logic [DIM_W-1:0] r,
		logic [DIM_W-1:0] s, logic [DIM_W-1:0] c);
		logic [7:0] t;
		t = 8'(r) * 8'(s) + 8'(c);
		return t[ADDR_W-1:0];
	endfunction

	assign n_eff  = (n_cfg_q == '0) ? 4'd1 :
		((n_cfg_q > DIM_W'(MAX_N)) ? DIM_W'(MAX_N) : n_cfg_q);
	assign nx_eff = (nx_cfg_q == '0) ? 4'd1 :
		((nx_cfg_q > DIM_W'(MAX_NX)) ? DIM_W'(MAX_NX) : nx_cfg_q);
	assign n_m1   = n_eff - 4'd1;
	assign nx_m1  = nx_eff - 4'd1;
	assign i_inc  = i_q + 4'd1;
	assign j_inc  = j_q + 4'd1;
	assign k_inc  = k_q + 4'd1;
	assign cap    = (in_opcode == OP_LOAD_B) ? 8'(n_eff) * 8'(nx_eff)
		: 8'(n_eff) * 8'(n_eff);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_cfg_q  <= DIM_W'(MAX_N);
			nx_cfg_q <= 4'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_N_SIZE:   n_cfg_q  <= cfg_data;
				CFG_RHS_COLS: nx_cfg_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			ld_cnt_q <= '0;
		end else begin
			state_q  <= state_d;
			i_q      <= i_d;
			j_q      <= j_d;
			k_q      <= k_d;
			ld_cnt_q <= ld_cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		k_d      = k_q;
		ld_cnt_d = ld_cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.op       = DP_NOP;
		cmd.num_sel  = NUM_A;
		cmd.out_kind = KIND_L;

		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.a_addr = ld_cnt_q[ADDR_W-1:0];
				cmd.b_addr = ld_cnt_q[ADDR_W-1:0];
				if (in_valid) begin
					if (8'(ld_cnt_q) < cap) begin
						cmd.a_we = (in_opcode == OP_LOAD_A);
						cmd.b_we = (in_opcode == OP_LOAD_B);
						ld_cnt_d = ld_cnt_q + 7'd1;
					end
					if (in_last) begin
						ld_cnt_d = '0;
						j_d      = '0;
						k_d      = '0;
						if (in_opcode == OP_LOAD_A) begin
							cmd.op  = DP_CLR_OK;
							state_d = ST_F_COL;
						end else if (status.spd) begin
							state_d = ST_FW_SUM;
						end else begin
							state_d = ST_S_REJ;
						end
					end
				end
			end

			// ---- factor: column j, off-diagonal k, inner i
			ST_F_COL: begin
				cmd.op  = DP_CLR_D;
				k_d     = '0;
				state_d = (j_q != '0) ? ST_F_SUM : ST_F_PIV;
			end
			ST_F_SUM: begin
				cmd.op  = DP_CLR_ACC;
				i_d     = '0;
				state_d = (k_q != '0) ? ST_F_RD1 : ST_F_RDA;
			end
			ST_F_RD1: begin
				cmd.f_addr = idx(k_q, DIM_W'(MAX_N), i_q);
				state_d    = ST_F_RD2;
			end
			ST_F_RD2: begin
				cmd.op     = DP_LD_OPA_F;
				cmd.f_addr = idx(j_q, DIM_W'(MAX_N), i_q);
				state_d    = ST_F_LDB;
			end
			ST_F_LDB: begin
				cmd.op  = DP_LD_OPB_F;
				state_d = ST_F_MUL;
			end
			ST_F_MUL: state_d = ST_F_ACC;
			ST_F_ACC: begin
				cmd.op  = DP_ACC;
				i_d     = i_inc;
				state_d = (i_inc < k_q) ? ST_F_RD1 : ST_F_RDA;
			end
			ST_F_RDA: begin
				cmd.a_addr = idx(j_q, n_eff, k_q);
				state_d    = ST_F_RDA2;
			end
			ST_F_RDA2: begin
				cmd.op     = DP_LD_SYM;
				cmd.a_addr = idx(k_q, n_eff, j_q);
				cmd.f_addr = idx(k_q, DIM_W'(MAX_N), k_q);
				state_d    = ST_F_DIV;
			end
			ST_F_DIV: begin
				cmd.op      = DP_DIV;
				cmd.num_sel = NUM_A;
				state_d     = ST_F_DIVW;
			end
			ST_F_DIVW: begin
				if (!status.ds_busy) begin
					cmd.op     = DP_LD_QQ;
					cmd.f_we   = 1'b1;
					cmd.f_addr = idx(j_q, DIM_W'(MAX_N), k_q);
					state_d    = ST_F_QMUL;
				end
			end
			ST_F_QMUL: state_d = ST_F_QACC;
			ST_F_QACC: begin
				cmd.op  = DP_DACC;
				k_d     = k_inc;
				state_d = (k_inc < j_q) ? ST_F_SUM : ST_F_PIV;
			end
			ST_F_PIV: begin
				cmd.a_addr = idx(j_q, n_eff, j_q);
				state_d    = ST_F_PIV2;
			end
			ST_F_PIV2: begin
				cmd.op  = DP_SQRT;
				state_d = ST_F_SQW;
			end
			ST_F_SQW: begin
				if (!status.ds_busy) begin
					cmd.f_we   = 1'b1;
					cmd.f_addr = idx(j_q, DIM_W'(MAX_N), j_q);
					j_d        = j_inc;
					state_d    = (j_inc < n_eff) ? ST_F_COL : ST_F_SPD;
				end
			end
			ST_F_SPD: begin
				cmd.op  = DP_SET_SPD;
				i_d     = '0;
				j_d     = '0;
				state_d = ST_LO_RD;
			end

			// ---- stream L, upper triangle as zero
			ST_LO_RD: begin
				if (!status.out_full) begin
					cmd.f_addr = idx(i_q, DIM_W'(MAX_N), j_q);
					state_d    = ST_LO_LD;
				end
			end
			ST_LO_LD: begin
				cmd.out_ld   = 1'b1;
				cmd.out_kind = KIND_L;
				cmd.out_zero = (j_q > i_q);
				cmd.out_end  = (i_q == n_m1) && (j_q == n_m1);
				state_d      = ST_LO_RD;
				if (j_q != n_m1) begin
					j_d = j_inc;
				end else begin
					j_d = '0;
					i_d = i_inc;
					if (i_q == n_m1) begin
						state_d = ST_IDLE;
					end
				end
			end

			ST_S_REJ: begin
				if (!status.out_full) begin
					cmd.out_ld   = 1'b1;
					cmd.out_kind = KIND_REJ;
					cmd.out_zero = 1'b1;
					cmd.out_end  = 1'b1;
					state_d      = ST_IDLE;
				end
			end

			// ---- forward substitution L*Y = B
			ST_FW_SUM: begin
				cmd.op  = DP_CLR_ACC;
				i_d     = '0;
				state_d = (k_q != '0) ? ST_FW_RD : ST_FW_RDB;
			end
			ST_FW_RD: begin
				cmd.x_addr = idx(i_q, nx_eff, j_q);
				cmd.f_addr = idx(k_q, DIM_W'(MAX_N), i_q);
				state_d    = ST_FW_LD;
			end
			ST_FW_LD: begin
				cmd.op  = DP_LD_XF;
				state_d = ST_FW_MUL;
			end
			ST_FW_MUL: state_d = ST_FW_ACC;
			ST_FW_ACC: begin
				cmd.op  = DP_ACC;
				i_d     = i_inc;
				state_d = (i_inc < k_q) ? ST_FW_RD : ST_FW_RDB;
			end
			ST_FW_RDB: begin
				cmd.b_addr = idx(k_q, nx_eff, j_q);
				cmd.f_addr = idx(k_q, DIM_W'(MAX_N), k_q);
				state_d    = ST_FW_DIV;
			end
			ST_FW_DIV: begin
				cmd.op      = DP_DIV;
				cmd.num_sel = NUM_B;
				state_d     = ST_FW_DW;
			end
			ST_FW_DW: begin
				if (!status.ds_busy) begin
					cmd.x_we   = 1'b1;
					cmd.x_addr = idx(k_q, nx_eff, j_q);
					state_d    = ST_FW_SUM;
					if (j_q != nx_m1) begin
						j_d = j_inc;
					end else begin
						j_d = '0;
						if (k_q != n_m1) begin
							k_d = k_inc;
						end else begin
							k_d     = n_m1;
							state_d = ST_BW_SUM;
						end
					end
				end
			end

			// ---- back substitution L'*X = Y
			ST_BW_SUM: begin
				cmd.op  = DP_CLR_ACC;
				i_d     = k_inc;
				state_d = (k_q != n_m1) ? ST_BW_RD : ST_BW_RDS;
			end
			ST_BW_RD: begin
				cmd.x_addr = idx(i_q, nx_eff, j_q);
				cmd.f_addr = idx(i_q, DIM_W'(MAX_N), k_q);
				state_d    = ST_BW_LD;
			end
			ST_BW_LD: begin
				cmd.op  = DP_LD_XF;
				state_d = ST_BW_MUL;
			end
			ST_BW_MUL: state_d = ST_BW_ACC;
			ST_BW_ACC: begin
				cmd.op  = DP_ACC;
				i_d     = i_inc;
				state_d = (i_inc < n_eff) ? ST_BW_RD : ST_BW_RDS;
			end
			ST_BW_RDS: begin
				cmd.x_addr = idx(k_q, nx_eff, j_q);
				cmd.f_addr = idx(k_q, DIM_W'(MAX_N), k_q);
				state_d    = ST_BW_DIV;
			end
			ST_BW_DIV: begin
				cmd.op      = DP_DIV;
				cmd.num_sel = NUM_X;
				state_d     = ST_BW_DW;
			end
			ST_BW_DW: begin
				if (!status.ds_busy) begin
					cmd.x_we   = 1'b1;
					cmd.x_addr = idx(k_q, nx_eff, j_q);
					state_d    = ST_BW_SUM;
					if (j_q != nx_m1) begin
						j_d = j_inc;
					end else begin
						j_d = '0;
						if (k_q != '0) begin
							k_d = k_q - 4'd1;
						end else begin
							i_d     = '0;
							state_d = ST_XO_RD;
						end
					end
				end
			end

			// ---- stream X
			ST_XO_RD: begin
				if (!status.out_full) begin
					cmd.x_addr = idx(i_q, nx_eff, j_q);
					state_d    = ST_XO_LD;
				end
			end
			ST_XO_LD: begin
				cmd.out_ld   = 1'b1;
				cmd.out_kind = KIND_X;
				cmd.out_end  = (i_q == n_m1) && (j_q == nx_m1);
				state_d      = ST_XO_RD;
				if (j_q != nx_m1) begin
					j_d = j_inc;
				end else begin
					j_d = '0;
					i_d = i_inc;
					if (i_q == n_m1) begin
						state_d = ST_IDLE;
					end
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### verif/cholesky_factor_solve_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cholesky_factor_solve_tb: self-checking bench for the Cholesky factor/solve
// A directed table covers reset behavior, single-element factors, clamped
// and zero pivots, ignored overflow loads and size clamping. Random phases
// then load full matrices and right-hand sides under changing sizes, plus
// noise. Every result item is checked against the table's expected value or a fixed-point predictor.
// ----------------------------------------------------------------------------
module cholesky_factor_solve_tb;
	import cfs_pkg::*;

	localparam int WATCHDOG_LIMIT = 60000;
	localparam int RANDOM_ITEMS   = 210;

	typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t        rk;
		logic             idx;
		logic [DIM_W-1:0] data;
		in_item_t         it;
		logic             typed;
		out_item_t        res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0] cfg_data = '0;

	always #5 clk = ~clk;

	cholesky_factor_solve u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// ---------------- predictor state ----------------
	int mdl_a [DEPTH];
	int mdl_l [DEPTH];
	int mdl_b [DEPTH];
	logic mdl_spd = 1'b0;
	int mdl_cnt = 0;
	logic [DIM_W-1:0] mdl_n = 4'd8;
	logic [DIM_W-1:0] mdl_nx = 4'd1;

	out_item_t result_q [$];
	int mismatches = 0;
	bit quiet = 0;		// no idling on either side while set
	int idle_cnt = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round half up: floor((a*b + 2^15) / 2^16)
	function automatic longint fix_mul(longint a, longint b);
		return (a * b + 64'sd32768) >>> 16;
	endfunction

	function automatic longint fix_div(longint num, longint den);
		if (den == 0) begin
			if (num > 0) return 64'sd2147483647;
			if (num < 0) return -64'sd2147483648;
			return 0;
		end
		return clamp32((num * 64'sd65536) / den);
	endfunction

	function automatic longint fix_sqrt(longint d);
		longint unsigned x, r, b;
		x = longint'(d) * 65536;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic int eff_n();
		if (mdl_n == 0) return 1;
		return (mdl_n > MAX_N) ? MAX_N : int'(mdl_n);
	endfunction

	function automatic int eff_nx();
		if (mdl_nx == 0) return 1;
		return (mdl_nx > MAX_NX) ? MAX_NX : int'(mdl_nx);
	endfunction

	function automatic out_item_t mk(kind_t k, longint v, logic s, logic e);
		out_item_t o;
		o.kind = k;
		o.result_value = v[31:0];
		o.spd = s;
		o.end_of_run = e;
		return o;
	endfunction

	function automatic void factor_model(bit push);
		int n;
		bit ok;
		longint d, piv, s, q;
		n = eff_n();
		ok = 1;
		for (int j = 0; j < n; j++) begin
			d = 0;
			for (int k = 0; k < j; k++) begin
				s = 0;
				for (int i = 0; i < k; i++)
					s += fix_mul(mdl_l[k*MAX_N+i], mdl_l[j*MAX_N+i]);
				q = fix_div(clamp32(longint'(mdl_a[j*n+k]) - s), mdl_l[k*MAX_N+k]);
				mdl_l[j*MAX_N+k] = int'(q);
				d += fix_mul(q, q);
				ok = ok && (mdl_a[k*n+j] == mdl_a[j*n+k]);
			end
			piv = clamp32(longint'(mdl_a[j*n+j]) - d);
			ok = ok && (piv > 0);
			mdl_l[j*MAX_N+j] = int'(fix_sqrt(piv > 0 ? piv : 0));
			for (int k = j + 1; k < n; k++) mdl_l[j*MAX_N+k] = 0;
		end
		mdl_spd = ok;
		if (push)
			for (int i = 0; i < n*n; i++)
				result_q.push_back(mk(KIND_L, mdl_l[(i/n)*MAX_N + i%n], ok, i == n*n-1));
	endfunction

	function automatic void solve_model(bit push);
		int n, nx;
		longint x [MAX_N][MAX_NX];
		longint s;
		n = eff_n();
		nx = eff_nx();
		if (!mdl_spd) begin
			if (push) result_q.push_back(mk(KIND_REJ, 0, 1'b0, 1'b1));
			return;
		end
		for (int i = 0; i < n; i++)
			for (int j = 0; j < nx; j++) x[i][j] = mdl_b[i*nx+j];
		// forward: L*Y = B
		for (int k = 0; k < n; k++)
			for (int j = 0; j < nx; j++) begin
				s = 0;
				for (int i = 0; i < k; i++) s += fix_mul(x[i][j], mdl_l[k*MAX_N+i]);
				x[k][j] = fix_div(clamp32(x[k][j] - s), mdl_l[k*MAX_N+k]);
			end
		// back: L'*X = Y
		for (int k = n - 1; k >= 0; k--)
			for (int j = 0; j < nx; j++) begin
				s = 0;
				for (int i = k + 1; i < n; i++) s += fix_mul(x[i][j], mdl_l[i*MAX_N+k]);
				x[k][j] = fix_div(clamp32(x[k][j] - s), mdl_l[k*MAX_N+k]);
			end
		if (push)
			for (int i = 0; i < n*nx; i++)
				result_q.push_back(mk(KIND_X, x[i/nx][i%nx], 1'b1, i == n*nx-1));
	endfunction

	// one accepted item: shared load counter, opcode picks the store
	function automatic void apply_item(in_item_t it, bit push);
		int cap;
		cap = (it.opcode == OP_LOAD_B) ? eff_n() * eff_nx() : eff_n() * eff_n();
		if (mdl_cnt < cap && mdl_cnt < DEPTH) begin
			if (it.opcode == OP_LOAD_B) mdl_b[mdl_cnt] = it.value;
			else mdl_a[mdl_cnt] = it.value;
			mdl_cnt++;
		end
		if (!it.last) return;
		mdl_cnt = 0;
		if (it.opcode == OP_LOAD_B) solve_model(push);
		else factor_model(push);
	endfunction

	function automatic bit roll_idle();
		return !quiet && ($urandom_range(99) < 14);
	endfunction

	// ---------------- drivers ----------------
	task automatic send_item(in_item_t it, bit typed, out_item_t res);
		while (roll_idle()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		apply_item(it, !typed);
		if (typed) result_q.push_back(res);
	endtask

	// block idle: all results back, plus slack for work that emits nothing
	task automatic drain();
		in_valid <= 1'b0;
		while (result_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// cfg_valid drops after each write, which keeps back-to-back writes apart
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_N_SIZE) mdl_n = data;
		else mdl_nx = data;
		@(posedge clk);
	endtask

	function automatic in_item_t mk_in(logic op, logic [31:0] v, logic l);
		in_item_t it;
		it.opcode = op;
		it.value = v;
		it.last = l;
		return it;
	endfunction

	// symmetric, diagonally dominant most of the time; raw noise otherwise
	task automatic load_matrix(bit spd_like);
		int n;
		int m [MAX_N][MAX_N];
		n = eff_n();
		for (int i = 0; i < n; i++)
			for (int j = 0; j <= i; j++) begin
				if (!spd_like) m[i][j] = $urandom;
				else if (i == j) m[i][j] = (n + 1) * 65536 + $urandom_range(65535);
				else m[i][j] = $urandom_range(131071) - 65536;
				m[j][i] = spd_like ? m[i][j] : $urandom;
			end
		for (int i = 0; i < n*n; i++)
			send_item(mk_in(OP_LOAD_A, m[i/n][i%n], i == n*n-1), 0, '0);
	endtask

	task automatic load_rhs(bit wide);
		int cnt;
		cnt = eff_n() * eff_nx();
		for (int i = 0; i < cnt; i++)
			send_item(mk_in(OP_LOAD_B, wide ? $urandom : $urandom_range(1 << 20) - (1 << 19),
				i == cnt-1), 0, '0);
	endtask

	// ---------------- result checker ----------------
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (result_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item: kind=%0d value=%h spd=%b end=%b",
						out_item.kind, out_item.result_value, out_item.spd,
						out_item.end_of_run);
			end else begin
				out_item_t exp_item;
				exp_item = result_q.pop_front();
				if (out_item.kind !== exp_item.kind
					|| out_item.result_value !== exp_item.result_value
					|| out_item.spd !== exp_item.spd
					|| out_item.end_of_run !== exp_item.end_of_run) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: exp kind=%0d value=%h spd=%b end=%b, got kind=%0d value=%h spd=%b end=%b",
							exp_item.kind, exp_item.result_value, exp_item.spd,
							exp_item.end_of_run, out_item.kind, out_item.result_value,
							out_item.spd, out_item.end_of_run);
				end
			end
		end
		out_ready <= !roll_idle();
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	stim_row_t rows [$];

	task automatic add_item(logic op, logic [31:0] v, logic l, logic typed, out_item_t res);
		stim_row_t r;
		r.rk = ROW_ITEM;
		r.idx = 0;
		r.data = 0;
		r.it = mk_in(op, v, l);
		r.typed = typed;
		r.res = res;
		rows.push_back(r);
	endtask

	task automatic add_cfg(logic idx, logic [DIM_W-1:0] data);
		stim_row_t r;
		r.rk = ROW_CFG;
		r.idx = idx;
		r.data = data;
		r.it = '0;
		r.typed = 0;
		r.res = '0;
		rows.push_back(r);
	endtask

	initial begin
		int rnd_items;
		out_item_t rej;
		for (int i = 0; i < DEPTH; i++) begin
			mdl_a[i] = 0;
			mdl_l[i] = 0;
			mdl_b[i] = 0;
		end
		rej = mk(KIND_REJ, 0, 1'b0, 1'b1);

		// solve straight after reset: no factor yet, so rejected
		add_item(OP_LOAD_B, 32'h0, 1, 1, rej);
		add_cfg(CFG_N_SIZE, 4'd1);
		// sqrt(4.0) = 2.0
		add_item(OP_LOAD_A, 32'h0004_0000, 1, 1, mk(KIND_L, 32'h0002_0000, 1, 1));
		add_item(OP_LOAD_B, 32'h0001_0000, 1, 0, '0);
		add_item(OP_LOAD_B, 32'h7fff_ffff, 1, 0, '0);
		add_item(OP_LOAD_B, 32'h8000_0000, 1, 0, '0);
		add_item(OP_LOAD_A, 32'h7fff_ffff, 1, 0, '0);
		add_item(OP_LOAD_B, 32'hffff_ffff, 1, 0, '0);
		// negative pivot clamps to zero, not SPD, then solve is rejected
		add_item(OP_LOAD_A, 32'h8000_0000, 1, 1, mk(KIND_L, 0, 0, 1));
		add_item(OP_LOAD_B, 32'h0, 1, 1, rej);
		add_item(OP_LOAD_A, 32'h0, 1, 1, mk(KIND_L, 0, 0, 1));
		// loads past the end are dropped; last one still starts the factor
		add_item(OP_LOAD_A, 32'h0000_0001, 0, 0, '0);
		add_item(OP_LOAD_A, 32'h1234_5678, 0, 0, '0);
		add_item(OP_LOAD_A, 32'h0000_7fff, 1, 1, mk(KIND_L, 32'h0000_0100, 1, 1));
		// counter shared across opcodes: B load, then A last is dropped
		add_item(OP_LOAD_B, 32'h0002_0000, 0, 0, '0);
		add_item(OP_LOAD_A, 32'hdead_beef, 1, 1, mk(KIND_L, 32'h0000_0100, 1, 1));
		add_item(OP_LOAD_B, 32'h5555_5555, 1, 0, '0);
		add_cfg(CFG_RHS_COLS, 4'd0);
		add_item(OP_LOAD_B, 32'haaaa_aaaa, 1, 0, '0);
		// n_size 0 acts as 1
		add_cfg(CFG_N_SIZE, 4'd0);
		add_item(OP_LOAD_A, 32'h0001_0000, 1, 1, mk(KIND_L, 32'h0001_0000, 1, 1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) begin
			if (rows[r].rk == ROW_CFG) begin
				drain();
				write_reg(rows[r].idx, rows[r].data);
			end else begin
				send_item(rows[r].it, rows[r].typed, rows[r].res);
			end
		end

		// fill every store entry at full size so later early lasts read known data
		drain();
		write_reg(CFG_N_SIZE, 4'd8);
		write_reg(CFG_RHS_COLS, 4'd8);
		load_matrix(1);
		load_rhs(0);
		rnd_items = 128;

		while (rnd_items < RANDOM_ITEMS) begin
			int pick, cnt;
			quiet = (rnd_items > 150 && rnd_items < 185);
			drain();
			if ($urandom_range(1)) begin
				write_reg(CFG_N_SIZE, ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8))
					: 4'($urandom_range(4)));
				write_reg(CFG_RHS_COLS, ($urandom_range(9) == 0) ? 4'($urandom_range(15, 8))
					: 4'($urandom_range(4)));
			end
			pick = $urandom_range(9);
			if (pick < 4) begin
				load_matrix(pick != 0);
				rnd_items += eff_n() * eff_n();
			end else if (pick < 8) begin
				load_rhs(pick == 7);
				rnd_items += eff_n() * eff_nx();
			end else begin
				// noise: mixed opcodes, arbitrary length, early or late last
				cnt = $urandom_range(eff_n() * eff_n() + 3, 1);
				for (int i = 0; i < cnt; i++)
					send_item(mk_in(1'($urandom), $urandom, i == cnt-1), 0, '0);
				rnd_items += cnt;
			end
		end
		quiet = 0;

		drain();
		repeat (3000) @(posedge clk);
		if (mismatches == 0 && result_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
